// ===== design/spmf_pkg.sv =====
package spmf_pkg;

   // Widths of the stream fields, fixed by the interface.
   localparam int PRI_W   = 8;
   localparam int TAG_W   = 6;
   localparam int SIZE_W  = 7;
   localparam int LEVEL_W = 4;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;

   // Operation codes carried in req_tuser.
   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_LINK,
      ST_POP_LINK
   } state_type;

endpackage

// ===== design/spmf_ram.sv =====
module spmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/strict_priority_multi_fifo_core.sv =====
// Strict-priority queue of linked FIFOs, one per level, with a per-tag link RAM.
// The result item is loaded into the output register on acceptance and shows in the cycle after.
// A successful pop, or a push onto a non-empty level, passes through a link state (link RAM
// read on a pop, its single write port on a push) before the next item is taken; any other item needs no extra state.
// Reset (synchronous, active high) empties all levels and the count; no clearing pass.
module strict_priority_multi_fifo_core #(
   parameter int NUM_LEVELS  = 9,
   parameter int NUM_TAGS    = 64,
   parameter int PRI_LOWEST  = -4,
   parameter int PRI_HIGHEST = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // priority_req [7:0], item_tag [13:8], zero [15:14]
   input  logic [spmf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // mode [0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_tag [5:0], size_before [12:6], level_used [16:13], zero [23:17]
   output logic [spmf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // out_valid [0]
   output logic [0:0]                          rsp_tuser
);

   localparam int TW    = $clog2(NUM_TAGS);
   localparam int LW    = $clog2(NUM_LEVELS);
   localparam int CW    = $clog2(NUM_TAGS + 1);
   localparam int LINKW = TW + 1;

   localparam logic signed [9:0] PRI_LO_S  = 10'(PRI_LOWEST);
   localparam logic signed [9:0] PRI_HI_S  = 10'(PRI_HIGHEST);
   localparam logic signed [9:0] LVL_MAX_S = 10'(NUM_LEVELS - 1);
   localparam logic [CW-1:0]     FULL_CNT  = CW'(NUM_TAGS);

   // Control state.
   spmf_pkg::state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Per-level head and tail pointers. Only read where the level is non-empty,
   // so they need no reset.
   logic [TW-1:0] head_ff [NUM_LEVELS];
   logic [TW-1:0] head_in [NUM_LEVELS];
   logic [TW-1:0] tail_ff [NUM_LEVELS];
   logic [TW-1:0] tail_in [NUM_LEVELS];

   // Context carried into the link state of an item.
   logic [LW-1:0] op_lvl_ff, op_lvl_in;
   logic [TW-1:0] link_tag_ff, link_tag_in;
   logic [TW-1:0] old_tail_ff, old_tail_in;

   // Output register.
   logic [spmf_pkg::TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [spmf_pkg::SIZE_W-1:0]  rsp_size_ff, rsp_size_in;
   logic [spmf_pkg::LEVEL_W-1:0] rsp_lvl_ff, rsp_lvl_in;

   // Link RAM: {link_valid, next_link} per tag.
   logic             ram_wr_en;
   logic [TW-1:0]    ram_wr_addr;
   logic [LINKW-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [TW-1:0]    ram_rd_addr;
   logic [LINKW-1:0] ram_rd_data;

   // Decoded request.
   logic                              req_mode;
   logic signed [spmf_pkg::PRI_W-1:0] req_pri;
   logic [spmf_pkg::TAG_W-1:0]        req_tag;
   logic                              accept;

   logic signed [9:0] pri_ext, pri_clamp, lvl_s;
   logic [LW-1:0]     push_lvl;
   logic [16:0]       tag_acc;
   logic [TW-1:0]     push_tag;
   logic [LW-1:0]     pop_lvl;
   logic              pop_found;

   assign req_mode = req_tuser[0];
   assign req_pri  = signed'(req_tdata[7:0]);
   assign req_tag  = req_tdata[13:8];

   // A new item is taken only between items, and only when the output
   // register is free or is being emptied in this cycle.
   assign req_tready = (state_ff == spmf_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Clamp the raw priority into the level range and bias it to a level index.
   always_comb begin
      pri_ext = {{2{req_pri[spmf_pkg::PRI_W-1]}}, req_pri};
      if (pri_ext < PRI_LO_S) begin
         pri_clamp = PRI_LO_S;
      end else if (pri_ext > PRI_HI_S) begin
         pri_clamp = PRI_HI_S;
      end else begin
         pri_clamp = pri_ext;
      end
      lvl_s = pri_clamp - PRI_LO_S;
      if (lvl_s > LVL_MAX_S) begin
         lvl_s = LVL_MAX_S;
      end
      push_lvl = lvl_s[LW-1:0];
   end

   // Reduce the tag modulo the tag count by conditional subtraction of
   // shifted multiples, largest first.
   always_comb begin
      tag_acc = 17'(req_tag);
      for (int k = 5; k >= 0; k--) begin
         if (tag_acc >= (17'(NUM_TAGS) << k)) begin
            tag_acc = tag_acc - (17'(NUM_TAGS) << k);
         end
      end
      push_tag = tag_acc[TW-1:0];
   end

   // Highest non-empty level; later matches override earlier ones.
   always_comb begin
      pop_lvl   = '0;
      pop_found = |nonempty_ff;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         if (nonempty_ff[i]) begin
            pop_lvl = LW'(i);
         end
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spmf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == spmf_pkg::MODE_PUSH) begin
                  if ((count_ff != FULL_CNT) && nonempty_ff[push_lvl]) begin
                     state_in = spmf_pkg::ST_PUSH_LINK;
                  end
               end else if ((count_ff != '0) && pop_found) begin
                  state_in = spmf_pkg::ST_POP_LINK;
               end
            end
         end
         spmf_pkg::ST_PUSH_LINK: begin
            state_in = spmf_pkg::ST_IDLE;
         end
         spmf_pkg::ST_POP_LINK: begin
            state_in = spmf_pkg::ST_IDLE;
         end
         default: begin
            state_in = spmf_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and RAM control.
   always_comb begin
      count_in     = count_ff;
      nonempty_in  = nonempty_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      op_lvl_in    = op_lvl_ff;
      link_tag_in  = link_tag_ff;
      old_tail_in  = old_tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tag_in   = rsp_tag_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = push_tag;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff[pop_lvl];

      unique case (state_ff)
         spmf_pkg::ST_IDLE: begin
            if (accept) begin
               // The result is fully known at acceptance.
               rsp_valid_in = 1'b1;
               rsp_size_in  = spmf_pkg::SIZE_W'(count_ff);
               rsp_tag_in   = '0;
               rsp_hit_in   = 1'b0;
               rsp_lvl_in   = '0;
               if (req_mode == spmf_pkg::MODE_PUSH) begin
                  rsp_lvl_in = spmf_pkg::LEVEL_W'(push_lvl);
                  if (count_ff != FULL_CNT) begin
                     // The pushed tag becomes a tail: its link is cleared first,
                     // so a re-pushed tail still ends up linked to itself.
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = push_tag;
                     ram_wr_data = '0;
                     count_in    = count_ff + CW'(1);
                     if (nonempty_ff[push_lvl]) begin
                        old_tail_in       = tail_ff[push_lvl];
                        link_tag_in       = push_tag;
                        tail_in[push_lvl] = push_tag;
                     end else begin
                        head_in[push_lvl]     = push_tag;
                        tail_in[push_lvl]     = push_tag;
                        nonempty_in[push_lvl] = 1'b1;
                     end
                  end
               end else if (count_ff != '0) begin
                  if (pop_found) begin
                     rsp_tag_in  = spmf_pkg::TAG_W'(head_ff[pop_lvl]);
                     rsp_hit_in  = 1'b1;
                     rsp_lvl_in  = spmf_pkg::LEVEL_W'(pop_lvl);
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = head_ff[pop_lvl];
                     op_lvl_in   = pop_lvl;
                     count_in    = count_ff - CW'(1);
                  end else begin
                     // A count with no list behind it can only follow a
                     // duplicate push; the pop drops it.
                     count_in = '0;
                  end
               end
            end
         end
         spmf_pkg::ST_PUSH_LINK: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = old_tail_ff;
            ram_wr_data = {1'b1, link_tag_ff};
         end
         spmf_pkg::ST_POP_LINK: begin
            // The link of the removed head is back from the RAM.
            if (ram_rd_data[TW]) begin
               head_in[op_lvl_ff] = ram_rd_data[TW-1:0];
            end else begin
               nonempty_in[op_lvl_ff] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spmf_pkg::ST_IDLE;
         count_ff     <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff     <= head_in;
      tail_ff     <= tail_in;
      op_lvl_ff   <= op_lvl_in;
      link_tag_ff <= link_tag_in;
      old_tail_ff <= old_tail_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_size_ff <= rsp_size_in;
      rsp_lvl_ff  <= rsp_lvl_in;
   end

   spmf_ram #(
      .WIDTH(LINKW),
      .DEPTH(NUM_TAGS)
   ) link_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {7'b0, rsp_lvl_ff, rsp_size_ff, rsp_tag_ff};
   assign rsp_tuser[0] = rsp_hit_ff;

endmodule
